### src/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the two-phase task dispatcher.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int DEF_MAX_FIRST  = 64;
  localparam int DEF_MAX_SECOND = 16;

  localparam int REQ_W      = 2;
  localparam int ID_W       = 6;
  localparam int NF_W       = 7;
  localparam int NS_W       = 5;
  localparam int WK_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TASK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXIT   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = 2'd2;

  // register reset values
  localparam logic [NF_W-1:0] NF_RESET = 7'd1;
  localparam logic [NS_W-1:0] NS_RESET = 5'd1;
  localparam logic [WK_W-1:0] WK_RESET = 8'd1;

  // task table entry codes
  localparam logic [1:0] TS_IDLE = 2'd0;
  localparam logic [1:0] TS_BUSY = 2'd1;
  localparam logic [1:0] TS_DONE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_F,
    ST_SCAN_S,
    ST_REP_RD,
    ST_REP_WR,
    ST_RESULT
  } fsm_t;

  typedef struct packed {
    logic            req;
    logic [WK_W-1:0] workers;
  } restart_t;

  typedef struct packed {
    logic            granted;
    logic            grant_kind;
    logic [ID_W-1:0] grant_id;
    logic            all_done;
    logic            shutdown;
    logic            status;
  } res_t;

endpackage

### src/tpd_if.sv
// ----------------------------------------------------------------------------
// tpd channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpd_req_if;
  logic                         valid;
  logic                         ready;
  logic [tpd_pkg::REQ_W-1:0]    req_type;
  logic                         task_kind;
  logic [tpd_pkg::ID_W-1:0]     task_id;

  modport source (output valid, req_type, task_kind, task_id, input ready);
  modport sink (input valid, req_type, task_kind, task_id, output ready);
endinterface

interface tpd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic                         grant_kind;
  logic [tpd_pkg::ID_W-1:0]     grant_id;
  logic                         all_done;
  logic                         shutdown;
  logic                         status;

  modport source (output valid, granted, grant_kind, grant_id, all_done, shutdown, status,
                  input ready);
  modport sink (input valid, granted, grant_kind, grant_id, all_done, shutdown, status,
                output ready);
endinterface

interface tpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpd_pkg::CFG_IDX_W-1:0]   index;
  logic [tpd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/two_phase_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// two_phase_task_dispatcher_unit
// Grants first-phase then second-phase tasks from two state tables, records
// completions and counts worker exits.
//
//   channel   dir   fields
//   req_ch    in    req_type, task_kind, task_id
//   res_ch    out   granted, grant_kind, grant_id, all_done, shutdown, status
//   cfg_ch    in    index, data (num_first_tasks, num_second_tasks, num_workers)
//
// one transaction at a time; a task request scans entries one per cycle in the first table,
// or in the second once every first-phase task is done
// an in-range completion report goes through ST_REP_RD and ST_REP_WR to ST_RESULT, an exit
// or any other transaction straight to ST_RESULT
// after reset and after every write to a defined register a clearing pass over
// max(MAX_FIRST_TASKS, MAX_SECOND_TASKS) entries holds req_ch.ready low
// a result waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
module two_phase_task_dispatcher_unit #(
  parameter int MAX_FIRST_TASKS  = tpd_pkg::DEF_MAX_FIRST,
  parameter int MAX_SECOND_TASKS = tpd_pkg::DEF_MAX_SECOND
) (
  input logic       clk,
  input logic       rst,
  tpd_req_if.sink   req_ch,
  tpd_res_if.source res_ch,
  tpd_cfg_if.sink   cfg_ch
);

  localparam int FN_W = $clog2(MAX_FIRST_TASKS + 1);
  localparam int SN_W = $clog2(MAX_SECOND_TASKS + 1);

  logic [tpd_pkg::NF_W-1:0] num_first_tasks;
  logic [tpd_pkg::NS_W-1:0] num_second_tasks;
  logic [tpd_pkg::WK_W-1:0] num_workers;

  logic              cfg_write;
  logic [FN_W-1:0]   nf;
  logic [SN_W-1:0]   ns;
  tpd_pkg::restart_t restart;
  tpd_pkg::res_t     res, res_q;
  logic              res_valid, res_ready, out_valid;
  logic              in_ready;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_first_tasks  <= tpd_pkg::NF_RESET;
      num_second_tasks <= tpd_pkg::NS_RESET;
      num_workers      <= tpd_pkg::WK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_ch.index)
        tpd_pkg::CFG_FIRST:   num_first_tasks  <= cfg_ch.data[tpd_pkg::NF_W-1:0];
        tpd_pkg::CFG_SECOND:  num_second_tasks <= cfg_ch.data[tpd_pkg::NS_W-1:0];
        tpd_pkg::CFG_WORKERS: num_workers      <= cfg_ch.data[tpd_pkg::WK_W-1:0];
        default: ;
      endcase
    end
  end

  // a write to any of the three defined registers starts a new job
  always_comb begin
    restart.req = cfg_write && ((cfg_ch.index == tpd_pkg::CFG_FIRST) ||
                                (cfg_ch.index == tpd_pkg::CFG_SECOND) ||
                                (cfg_ch.index == tpd_pkg::CFG_WORKERS));
    restart.workers = (cfg_ch.index == tpd_pkg::CFG_WORKERS) ?
                      cfg_ch.data[tpd_pkg::WK_W-1:0] : num_workers;
  end

  // task counts saturated to the table sizes
  assign nf = (32'(num_first_tasks) > 32'(MAX_FIRST_TASKS)) ?
              FN_W'(MAX_FIRST_TASKS) : FN_W'(num_first_tasks);
  assign ns = (32'(num_second_tasks) > 32'(MAX_SECOND_TASKS)) ?
              SN_W'(MAX_SECOND_TASKS) : SN_W'(num_second_tasks);

  assign req_ch.ready = in_ready && !cfg_ch.valid;

  tpd_ctrl #(
    .MAX_FIRST_TASKS  (MAX_FIRST_TASKS),
    .MAX_SECOND_TASKS (MAX_SECOND_TASKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_ch.valid && !cfg_ch.valid),
    .in_ready  (in_ready),
    .req_type  (req_ch.req_type),
    .task_kind (req_ch.task_kind),
    .task_id   (req_ch.task_id),
    .nf        (nf),
    .ns        (ns),
    .restart   (restart),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign res_ch.valid      = out_valid;
  assign res_ch.granted    = res_q.granted;
  assign res_ch.grant_kind = res_q.grant_kind;
  assign res_ch.grant_id   = res_q.grant_id;
  assign res_ch.all_done   = res_q.all_done;
  assign res_ch.shutdown   = res_q.shutdown;
  assign res_ch.status     = res_q.status;

endmodule

### src/tpd_state_ram.sv
// ----------------------------------------------------------------------------
// tpd_state_ram
// Task state table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpd_state_ram #(
  parameter int DEPTH = tpd_pkg::DEF_MAX_FIRST,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/tpd_ctrl.sv
// ----------------------------------------------------------------------------
// tpd_ctrl
// Sequencer over the two task tables: clearing pass, grant scan,
// completion read-modify-write, done counters and worker count.
// ----------------------------------------------------------------------------
module tpd_ctrl #(
  parameter int MAX_FIRST_TASKS  = tpd_pkg::DEF_MAX_FIRST,
  parameter int MAX_SECOND_TASKS = tpd_pkg::DEF_MAX_SECOND
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [tpd_pkg::REQ_W-1:0]              req_type,
  input  logic                                   task_kind,
  input  logic [tpd_pkg::ID_W-1:0]               task_id,
  input  logic [$clog2(MAX_FIRST_TASKS+1)-1:0]   nf,
  input  logic [$clog2(MAX_SECOND_TASKS+1)-1:0]  ns,
  input  tpd_pkg::restart_t                      restart,
  output tpd_pkg::res_t                          res,
  output logic                                   res_valid,
  input  logic                                   res_ready
);

  localparam int FN_W  = $clog2(MAX_FIRST_TASKS + 1);
  localparam int SN_W  = $clog2(MAX_SECOND_TASKS + 1);
  localparam int FA_W  = (MAX_FIRST_TASKS > 1) ? $clog2(MAX_FIRST_TASKS) : 1;
  localparam int SA_W  = (MAX_SECOND_TASKS > 1) ? $clog2(MAX_SECOND_TASKS) : 1;
  localparam int SC_W  = (FN_W > SN_W) ? FN_W : SN_W;
  localparam int CLR_N = (MAX_FIRST_TASKS > MAX_SECOND_TASKS) ? MAX_FIRST_TASKS
                                                              : MAX_SECOND_TASKS;
  localparam int CLR_W = $clog2(CLR_N + 1);

  tpd_pkg::fsm_t state, state_next;

  logic [SC_W-1:0]             scan_idx;
  logic [SC_W-1:0]             chk_idx;
  logic                        pend;
  logic                        kind_q;
  logic [tpd_pkg::ID_W-1:0]    id_q;
  logic                        granted_q;
  logic                        gkind_q;
  logic [tpd_pkg::ID_W-1:0]    gid_q;
  logic                        status_q;
  logic [FN_W-1:0]             f_done;
  logic [SN_W-1:0]             s_done;
  logic [tpd_pkg::WK_W-1:0]    workers_left;
  logic [CLR_W-1:0]            clr_idx;

  logic            fa_we, sa_we;
  logic [FA_W-1:0] fa_waddr, fa_raddr;
  logic [SA_W-1:0] sa_waddr, sa_raddr;
  logic [1:0]      fa_wdata, sa_wdata, fa_rdata, sa_rdata;

  logic            accept;
  logic            id_ok;
  logic            first_all;
  logic [SC_W-1:0] scan_n;
  logic            scan_more;
  logic [1:0]      scan_data;
  logic            hit;
  logic [1:0]      old_state;
  logic            clr_last;

  tpd_state_ram #(
    .DEPTH (MAX_FIRST_TASKS),
    .AW    (FA_W)
  ) u_first_ram (
    .clk   (clk),
    .we    (fa_we),
    .waddr (fa_waddr),
    .wdata (fa_wdata),
    .raddr (fa_raddr),
    .rdata (fa_rdata)
  );

  tpd_state_ram #(
    .DEPTH (MAX_SECOND_TASKS),
    .AW    (SA_W)
  ) u_second_ram (
    .clk   (clk),
    .we    (sa_we),
    .waddr (sa_waddr),
    .wdata (sa_wdata),
    .raddr (sa_raddr),
    .rdata (sa_rdata)
  );

  assign accept    = in_valid && in_ready;
  assign id_ok     = task_kind ? (32'(task_id) < 32'(ns)) : (32'(task_id) < 32'(nf));
  assign first_all = (f_done == nf);
  assign scan_n    = (state == tpd_pkg::ST_SCAN_S) ? SC_W'(ns) : SC_W'(nf);
  assign scan_more = (scan_idx < scan_n);
  assign scan_data = (state == tpd_pkg::ST_SCAN_S) ? sa_rdata : fa_rdata;
  assign hit       = pend && (scan_data == tpd_pkg::TS_IDLE);
  assign old_state = kind_q ? sa_rdata : fa_rdata;
  assign clr_last  = (clr_idx == CLR_W'(CLR_N - 1));

  // next state
  always_comb begin
    state_next = state;
    if (restart.req) begin
      state_next = tpd_pkg::ST_CLEAR;
    end else begin
      unique case (state)
        tpd_pkg::ST_CLEAR: begin
          if (clr_last) state_next = tpd_pkg::ST_IDLE;
        end
        tpd_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (req_type)
              tpd_pkg::REQ_TASK: begin
                state_next = first_all ? tpd_pkg::ST_SCAN_S : tpd_pkg::ST_SCAN_F;
              end
              tpd_pkg::REQ_REPORT: begin
                state_next = id_ok ? tpd_pkg::ST_REP_RD : tpd_pkg::ST_RESULT;
              end
              default: state_next = tpd_pkg::ST_RESULT;
            endcase
          end
        end
        tpd_pkg::ST_SCAN_F, tpd_pkg::ST_SCAN_S: begin
          if (hit || (!scan_more && !pend)) state_next = tpd_pkg::ST_RESULT;
        end
        tpd_pkg::ST_REP_RD: state_next = tpd_pkg::ST_REP_WR;
        tpd_pkg::ST_REP_WR: state_next = tpd_pkg::ST_RESULT;
        tpd_pkg::ST_RESULT: begin
          if (res_ready) state_next = tpd_pkg::ST_IDLE;
        end
        default: state_next = tpd_pkg::ST_CLEAR;
      endcase
    end
  end

  // table ports and handshake outputs
  always_comb begin
    fa_we    = 1'b0;
    sa_we    = 1'b0;
    fa_wdata = tpd_pkg::TS_IDLE;
    sa_wdata = tpd_pkg::TS_IDLE;
    fa_waddr = FA_W'(chk_idx);
    sa_waddr = SA_W'(chk_idx);
    fa_raddr = FA_W'(scan_idx);
    sa_raddr = SA_W'(scan_idx);
    in_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      tpd_pkg::ST_CLEAR: begin
        fa_we    = (32'(clr_idx) < 32'(MAX_FIRST_TASKS));
        sa_we    = (32'(clr_idx) < 32'(MAX_SECOND_TASKS));
        fa_waddr = FA_W'(clr_idx);
        sa_waddr = SA_W'(clr_idx);
      end
      tpd_pkg::ST_IDLE: in_ready = 1'b1;
      tpd_pkg::ST_SCAN_F: begin
        fa_we    = hit;
        fa_wdata = tpd_pkg::TS_BUSY;
      end
      tpd_pkg::ST_SCAN_S: begin
        sa_we    = hit;
        sa_wdata = tpd_pkg::TS_BUSY;
      end
      tpd_pkg::ST_REP_RD: begin
        fa_raddr = FA_W'(id_q);
        sa_raddr = SA_W'(id_q);
      end
      tpd_pkg::ST_REP_WR: begin
        fa_we    = !kind_q;
        sa_we    = kind_q;
        fa_wdata = tpd_pkg::TS_DONE;
        sa_wdata = tpd_pkg::TS_DONE;
        fa_waddr = FA_W'(id_q);
        sa_waddr = SA_W'(id_q);
      end
      tpd_pkg::ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.granted    = granted_q;
    res.grant_kind = gkind_q;
    res.grant_id   = gid_q;
    res.all_done   = (s_done == ns);
    res.shutdown   = (workers_left == '0);
    res.status     = status_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tpd_pkg::ST_CLEAR;
      clr_idx      <= '0;
      f_done       <= '0;
      s_done       <= '0;
      workers_left <= tpd_pkg::WK_RESET;
      pend         <= 1'b0;
    end else begin
      state <= state_next;
      if (restart.req) begin
        clr_idx      <= '0;
        f_done       <= '0;
        s_done       <= '0;
        workers_left <= restart.workers;
        pend         <= 1'b0;
      end else begin
        unique case (state)
          tpd_pkg::ST_CLEAR: begin
            if (!clr_last) clr_idx <= clr_idx + CLR_W'(1);
          end
          tpd_pkg::ST_IDLE: begin
            if (accept) begin
              kind_q    <= task_kind;
              id_q      <= task_id;
              granted_q <= 1'b0;
              gkind_q   <= 1'b0;
              gid_q     <= '0;
              status_q  <= (req_type == tpd_pkg::REQ_REPORT) && !id_ok;
              scan_idx  <= '0;
              pend      <= 1'b0;
              if ((req_type == tpd_pkg::REQ_EXIT) && (workers_left != '0)) begin
                workers_left <= workers_left - tpd_pkg::WK_W'(1);
              end
            end
          end
          tpd_pkg::ST_SCAN_F, tpd_pkg::ST_SCAN_S: begin
            if (hit) begin
              granted_q <= 1'b1;
              gkind_q   <= (state == tpd_pkg::ST_SCAN_S);
              gid_q     <= tpd_pkg::ID_W'(chk_idx);
              pend      <= 1'b0;
            end else begin
              pend <= scan_more;
              if (scan_more) begin
                chk_idx  <= scan_idx;
                scan_idx <= scan_idx + SC_W'(1);
              end
            end
          end
          tpd_pkg::ST_REP_WR: begin
            if (old_state != tpd_pkg::TS_DONE) begin
              if (kind_q) s_done <= s_done + SN_W'(1);
              else f_done <= f_done + FN_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### dv/tb_two_phase_task_dispatcher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_phase_task_dispatcher_unit
// Self-checking bench for the two-phase task dispatcher. A queue-fed driver
// sends directed and randomly built jobs (grant, complete, exit, plus noise),
// a built-in predictor tracks both task tables and the worker count, and a
// monitor checks every result in order against the predicted one.
// ----------------------------------------------------------------------------
module tb_two_phase_task_dispatcher_unit;
  import tpd_pkg::*;

  localparam int MAX_CYCLES   = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTED = 10;
  localparam int ITEM_TARGET  = 1500;
  localparam int IDLE_PCT     = 11;

  localparam logic [REQ_W-1:0]     REQ_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam logic                 KIND_FIRST  = 1'b0;
  localparam logic                 KIND_SECOND = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             task_kind;
    logic [ID_W-1:0]  task_id;
  } dispatch_req_t;

  logic clk;
  logic rst;

  tpd_req_if req_ch ();
  tpd_res_if res_ch ();
  tpd_cfg_if cfg_ch ();

  two_phase_task_dispatcher_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted dispatcher state
  logic [1:0]      map_state    [DEF_MAX_FIRST];
  logic [1:0]      reduce_state [DEF_MAX_SECOND];
  logic [WK_W-1:0] live_workers;
  logic [NF_W-1:0] first_cfg;
  logic [NS_W-1:0] second_cfg;
  logic [WK_W-1:0] workers_cfg;

  dispatch_req_t pending_reqs [$];
  res_t          expected_res [$];

  int   items_planned;
  int   items_sent;
  int   results_checked;
  int   mismatches;
  int   cycles;
  int   cfg_writes;
  int   jobs;
  int   first_grants;
  int   second_grants;
  int   range_errors;
  int   hold_at;
  int   hold_left;
  bit   hold_fired;
  bit   no_gaps;
  res_t got_res;
  res_t want_res;

  function automatic int span(input int v, input int cap);
    return (v > cap) ? cap : v;
  endfunction

  function automatic void restart_tables();
    foreach (map_state[i]) map_state[i] = TS_IDLE;
    foreach (reduce_state[i]) reduce_state[i] = TS_IDLE;
    live_workers = workers_cfg;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_FIRST:   first_cfg = value[NF_W-1:0];
      CFG_SECOND:  second_cfg = value[NS_W-1:0];
      CFG_WORKERS: workers_cfg = value;
      default:     return;
    endcase
    restart_tables();
  endfunction

  function automatic res_t dispatch_step(input dispatch_req_t r);
    res_t res;
    int   nf;
    int   ns;
    int   i;
    bit   first_done;
    res = '0;
    nf = span(first_cfg, DEF_MAX_FIRST);
    ns = span(second_cfg, DEF_MAX_SECOND);
    case (r.req_type)
      REQ_TASK: begin
        first_done = 1'b1;
        for (i = 0; i < nf && !res.granted; i++) begin
          if (map_state[i] == TS_IDLE) begin
            map_state[i] = TS_BUSY;
            res.granted = 1'b1;
            res.grant_kind = KIND_FIRST;
            res.grant_id = ID_W'(i);
          end else if (map_state[i] != TS_DONE) begin
            first_done = 1'b0;
          end
        end
        if (!res.granted && first_done) begin
          for (i = 0; i < ns && !res.granted; i++) begin
            if (reduce_state[i] == TS_IDLE) begin
              reduce_state[i] = TS_BUSY;
              res.granted = 1'b1;
              res.grant_kind = KIND_SECOND;
              res.grant_id = ID_W'(i);
            end
          end
        end
      end
      REQ_REPORT: begin
        if (r.task_kind == KIND_FIRST) begin
          if (r.task_id < nf) map_state[r.task_id] = TS_DONE;
          else res.status = 1'b1;
        end else begin
          if (r.task_id < ns) reduce_state[r.task_id] = TS_DONE;
          else res.status = 1'b1;
        end
      end
      REQ_EXIT: begin
        if (live_workers != 0) live_workers = live_workers - 1'b1;
      end
      default: ;
    endcase
    res.all_done = 1'b1;
    for (i = 0; i < ns; i++)
      if (reduce_state[i] != TS_DONE) res.all_done = 1'b0;
    res.shutdown = (live_workers == 0);
    return res;
  endfunction

  task automatic add_req(input logic [REQ_W-1:0] rt, input int kind, input int id);
    dispatch_req_t r;
    r.req_type = rt;
    r.task_kind = 1'(kind);
    r.task_id = ID_W'(id);
    pending_reqs.insert(pending_reqs.size(), r);
    items_planned++;
  endtask

  task automatic add_noise(input int nf, input int ns);
    logic kind;
    int   n;
    kind = 1'($urandom_range(1));
    n = kind ? ns : nf;
    case ($urandom_range(4))
      0: add_req(REQ_REPORT, kind, (n < 64) ? $urandom_range(63, n) : $urandom_range(63));
      1: add_req(REQ_UNUSED, kind, $urandom_range(63));
      2: add_req(REQ_EXIT, kind, $urandom_range(63));
      3: add_req(REQ_REPORT, kind, (n > 0) ? $urandom_range(n - 1) : $urandom_range(63));
      default: add_req(REQ_TASK, kind, $urandom_range(63));
    endcase
  endtask

  task automatic maybe_noise(input int nf, input int ns);
    if ($urandom_range(99) < 6) add_noise(nf, ns);
    if ($urandom_range(99) < 4) add_req(REQ_EXIT, $urandom_range(1), $urandom_range(63));
  endtask

  // one well-formed job: grant all, complete in random order, then phase two
  task automatic plan_job(input int nf, input int ns);
    int perm [64];
    int i;
    int j;
    int t;
    for (i = 0; i < nf; i++) begin
      maybe_noise(nf, ns);
      add_req(REQ_TASK, $urandom_range(1), $urandom_range(63));
    end
    for (i = 0; i < nf; i++) perm[i] = i;
    for (i = nf - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < nf; i++) begin
      add_req(REQ_REPORT, KIND_FIRST, perm[i]);
      if ($urandom_range(99) < 15) add_req(REQ_TASK, $urandom_range(1), $urandom_range(63));
      maybe_noise(nf, ns);
    end
    for (i = 0; i < ns; i++) begin
      add_req(REQ_TASK, $urandom_range(1), $urandom_range(63));
      maybe_noise(nf, ns);
    end
    for (i = 0; i < ns; i++) perm[i] = i;
    for (i = ns - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < ns; i++) begin
      add_req(REQ_REPORT, KIND_SECOND, perm[i]);
      if ($urandom_range(99) < 15) add_req(REQ_TASK, $urandom_range(1), $urandom_range(63));
      maybe_noise(nf, ns);
    end
    add_req(REQ_TASK, $urandom_range(1), $urandom_range(63));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    apply_reg(idx, value);
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_reqs.size() != 0 || expected_res.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_job(input logic [7:0] fd, input logic [7:0] sd, input logic [7:0] wd);
    wait_drain();
    write_reg(CFG_FIRST, fd);
    write_reg(CFG_SECOND, sd);
    write_reg(CFG_WORKERS, wd);
    if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, 8'($urandom_range(255)));
    jobs++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_res.insert(expected_res.size(), dispatch_step(pending_reqs.pop_front()));
        items_sent++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          req_ch.valid     <= 1'b1;
          req_ch.req_type  <= pending_reqs[0].req_type;
          req_ch.task_kind <= pending_reqs[0].task_kind;
          req_ch.task_id   <= pending_reqs[0].task_id;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long result back-pressure, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_fired && items_sent == hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got_res.granted    = res_ch.granted;
        got_res.grant_kind = res_ch.grant_kind;
        got_res.grant_id   = res_ch.grant_id;
        got_res.all_done   = res_ch.all_done;
        got_res.shutdown   = res_ch.shutdown;
        got_res.status     = res_ch.status;
        if (expected_res.size() == 0) begin
          if (mismatches < MAX_REPORTED)
            $display("%0t: result with no transaction pending", $realtime);
          mismatches++;
        end else begin
          want_res = expected_res.pop_front();
          results_checked++;
          if (want_res.granted && want_res.grant_kind == KIND_FIRST) first_grants++;
          if (want_res.granted && want_res.grant_kind == KIND_SECOND) second_grants++;
          if (want_res.status) range_errors++;
          if (got_res !== want_res) begin
            if (mismatches < MAX_REPORTED) begin
              $display("%0t: result %0d exp granted=%0b kind=%0b id=%0d done=%0b shut=%0b st=%0b",
                       $realtime, results_checked, want_res.granted, want_res.grant_kind,
                       want_res.grant_id, want_res.all_done, want_res.shutdown, want_res.status);
              $display("%0t: result %0d got granted=%0b kind=%0b id=%0d done=%0b shut=%0b st=%0b",
                       $realtime, results_checked, got_res.granted, got_res.grant_kind,
                       got_res.grant_id, got_res.all_done, got_res.shutdown, got_res.status);
            end
            mismatches++;
          end
        end
      end
      res_ch.ready <= (hold_left == 0) && (no_gaps || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_res.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [7:0] fd;
    logic [7:0] sd;
    logic [7:0] wd;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_FIRST;
    cfg_ch.data <= '0;
    hold_at = -1;
    first_cfg = NF_RESET;
    second_cfg = NS_RESET;
    workers_cfg = WK_RESET;
    restart_tables();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: one task per phase, one worker
    jobs = 1;
    add_req(REQ_TASK, KIND_FIRST, 0);
    add_req(REQ_TASK, KIND_SECOND, 63);
    add_req(REQ_REPORT, KIND_FIRST, 63);
    add_req(REQ_REPORT, KIND_FIRST, 0);
    add_req(REQ_REPORT, KIND_SECOND, 1);
    add_req(REQ_TASK, KIND_FIRST, 0);
    add_req(REQ_TASK, KIND_FIRST, 0);
    add_req(REQ_REPORT, KIND_SECOND, 0);
    add_req(REQ_UNUSED, KIND_SECOND, 42);
    add_req(REQ_EXIT, KIND_FIRST, 0);
    add_req(REQ_EXIT, KIND_FIRST, 0);
    add_req(REQ_REPORT, KIND_FIRST, 0);

    // zero tasks in both phases
    start_job(8'd0, 8'd0, 8'd255);
    add_req(REQ_TASK, KIND_FIRST, 0);
    add_req(REQ_REPORT, KIND_FIRST, 0);
    add_req(REQ_REPORT, KIND_SECOND, 0);
    add_req(REQ_EXIT, KIND_SECOND, 21);

    // counts above table size saturate
    start_job(8'hFF, 8'hFF, 8'd2);
    add_req(REQ_REPORT, KIND_FIRST, 63);
    add_req(REQ_REPORT, KIND_SECOND, 15);
    add_req(REQ_REPORT, KIND_SECOND, 16);
    add_req(REQ_TASK, KIND_FIRST, 0);
    wait_drain();
    write_reg(CFG_UNUSED, 8'h5A);
    add_req(REQ_TASK, KIND_FIRST, 0);
    add_req(REQ_EXIT, KIND_FIRST, 0);
    add_req(REQ_EXIT, KIND_FIRST, 0);
    add_req(REQ_EXIT, KIND_FIRST, 0);

    // full tables, with the result side held off for a while
    start_job(8'd64, 8'd16, 8'($urandom_range(255, 1)));
    hold_at = items_sent + 20;
    plan_job(DEF_MAX_FIRST, DEF_MAX_SECOND);

    while (items_planned < ITEM_TARGET) begin
      if ($urandom_range(9) == 0) begin
        fd = 8'($urandom_range(255));
        sd = 8'($urandom_range(255));
      end else begin
        fd = 8'($urandom_range(8));
        sd = 8'($urandom_range(4));
      end
      wd = ($urandom_range(2) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      no_gaps = (jobs >= 12 && jobs < 18);
      start_job(fd, sd, wd);
      plan_job(span(fd & 8'h7F, DEF_MAX_FIRST), span(sd & 8'h1F, DEF_MAX_SECOND));
    end

    wait_drain();
    repeat (20) @(posedge clk);
    $display("checked %0d results from %0d transactions over %0d jobs, %0d register writes",
             results_checked, items_sent, jobs, cfg_writes);
    $display("granted %0d first-phase and %0d second-phase tasks, %0d out-of-range reports",
             first_grants, second_grants, range_errors);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### two_phase_task_dispatcher_unit.f
src/tpd_pkg.sv
src/tpd_if.sv
src/tpd_state_ram.sv
src/tpd_ctrl.sv
src/two_phase_task_dispatcher_unit.sv
dv/tb_two_phase_task_dispatcher_unit.sv
